// ----- rtl/cdis_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cyclic dominance invasion step: shared definitions
// Species and outcome codes, register indexes, field widths and the request,
// result and configuration payload types.
// ----------------------------------------------------------------------------
package cdis_pkg;

	// Field and counter widths
	localparam int NODE_W     = 12;
	localparam int ADDR_SPACE = 4096;
	localparam int RATE_BITS  = 16;
	localparam int RATE_W     = RATE_BITS + 1;
	localparam int RND_W      = 16;
	localparam int CNT_W      = 17;
	localparam int TOTAL_W    = 13;
	localparam int ATT_W      = 48;
	localparam int REG_IDX_W  = 2;

	localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(65535);
	localparam logic [ATT_W-1:0] ATT_MAX = '1;

	// Species codes
	typedef logic [1:0] species_t;
	localparam species_t SP_ROCK     = 2'd0;
	localparam species_t SP_PAPER    = 2'd1;
	localparam species_t SP_SCISSORS = 2'd2;
	localparam species_t SP_NONE     = 2'd3;

	// Request operations
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_ATTEMPT = 1'b1;

	// Result outcome codes
	typedef logic [1:0] outcome_t;
	localparam outcome_t OUT_RUNNING = 2'd0;
	localparam outcome_t OUT_EXTINCT = 2'd1;
	localparam outcome_t OUT_LIMIT   = 2'd2;

	// Configuration register indexes
	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_RATE_ROCK     = 2'd0;
	localparam reg_idx_t REG_RATE_PAPER    = 2'd1;
	localparam reg_idx_t REG_RATE_SCISSORS = 2'd2;
	localparam reg_idx_t REG_ATTEMPT_LIMIT = 2'd3;

	typedef logic [CNT_W-1:0] count_t;

	typedef struct packed {
		logic               operation;
		logic [NODE_W-1:0]  reference_node;
		logic [NODE_W-1:0]  neighbour_node;
		logic [RND_W-1:0]   random_fraction;
		species_t           load_species;
	} item_t;

	typedef struct packed {
		logic               replaced;
		outcome_t           outcome;
		species_t           extinct_kind;
		logic [ATT_W-1:0]   attempts_done;
		logic [TOTAL_W-1:0] rock_total;
		logic [TOTAL_W-1:0] paper_total;
		logic [TOTAL_W-1:0] scissors_total;
	} result_t;

	typedef struct packed {
		reg_idx_t           reg_index;
		logic [ATT_W-1:0]   data;
	} cfg_t;

	// Species that the given one beats
	function automatic species_t prey_of(input species_t s);
		species_t p;
		case (s)
			SP_ROCK:     p = SP_SCISSORS;
			SP_PAPER:    p = SP_ROCK;
			SP_SCISSORS: p = SP_PAPER;
			default:     p = SP_NONE;
		endcase
		return p;
	endfunction

	// First species with a zero count, rock first
	function automatic species_t first_extinct(input count_t r, input count_t p,
		input count_t s);
		species_t e;
		if (r == '0)
			e = SP_ROCK;
		else if (p == '0)
			e = SP_PAPER;
		else if (s == '0)
			e = SP_SCISSORS;
		else
			e = SP_NONE;
		return e;
	endfunction

endpackage

// ----- rtl/cdis_chan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready channel
// Generic handshake channel: a request moves when valid and ready are both
// high at a rising clock edge.
// ----------------------------------------------------------------------------
interface cdis_chan_if #(parameter type payload_t = logic) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);

endinterface

// ----- rtl/cyclic_dominance_invasion_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cyclic dominance invasion step
// Rock-paper-scissors lattice engine: per-node species memory, species
// counts and attempt counter, driven by load and invasion attempt requests.
// ----------------------------------------------------------------------------
// In the accept cycle of a request both node entries are read from the single
// species memory; in the execute state, held while an earlier result is not
// yet taken, the random fraction is compared against the winner's rate, the
// counts are updated, the loser node is written back and the result is
// registered. The result register lets the next request be accepted while a
// finished result still waits. After reset the species memory is cleared to
// rock, one entry per cycle over min(NODES, 4096) entries; no request is
// accepted until that pass is done; configuration writes are always taken.
// ----------------------------------------------------------------------------
module cyclic_dominance_invasion_step #(
	parameter int NODES = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	cdis_chan_if.sink         item,
	cdis_chan_if.sink         cfg,
	cdis_chan_if.source       result
);

	import cdis_pkg::*;

	localparam int DEPTH  = (NODES < ADDR_SPACE) ? NODES : ADDR_SPACE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
	localparam count_t NODES_C = CNT_W'(NODES);

	typedef enum logic {ST_IDLE, ST_EXEC} state_t;

	state_t              state_q;
	logic                res_valid_q;
	result_t             res_q;
	count_t              cnt_q [3];
	logic [ATT_W-1:0]    att_q;
	logic [RATE_W-1:0]   rate_q [3];
	logic [ATT_W-1:0]    limit_q;
	logic                clr_busy_q;
	logic [ADDR_W-1:0]   clr_addr_q;

	item_t               item_s1;
	logic                ref_ok_s1;
	logic                nbr_ok_s1;
	species_t            rd_ref_s1;
	species_t            rd_nbr_s1;

	species_t            spc_mem [DEPTH];

	item_t               req;
	cfg_t                cfg_req;
	logic                item_fire;
	logic                exec_fire;

	// Handshakes
	assign req       = item.payload;
	assign cfg_req   = cfg.payload;
	assign item.ready = (state_q == ST_IDLE) && !clr_busy_q;
	assign cfg.ready  = 1'b1;
	assign item_fire  = item.valid && item.ready;
	assign exec_fire  = (state_q == ST_EXEC) && (!res_valid_q || result.ready);
	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

	// Request capture
	always_ff @(posedge clk) begin
		if (item_fire) begin
			item_s1   <= req;
			ref_ok_s1 <= CNT_W'(req.reference_node) < NODES_C;
			nbr_ok_s1 <= CNT_W'(req.neighbour_node) < NODES_C;
		end
	end

	// Species memory: two registered reads at accept, one write
	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	species_t            wr_data;

	always_ff @(posedge clk) begin
		if (item_fire) begin
			rd_ref_s1 <= spc_mem[req.reference_node[ADDR_W-1:0]];
			rd_nbr_s1 <= spc_mem[req.neighbour_node[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			spc_mem[wr_addr] <= wr_data;
	end

	// Execute: decide the interaction and the new counts
	species_t            ext_pre;
	logic                lim_pre;
	logic                ref_wins;
	species_t            winner;
	species_t            loser;
	logic [RATE_W-1:0]   rate_sel;
	logic                hit;
	logic                interact;
	logic                active;
	logic                dec_en;
	logic                inc_en;
	species_t            dec_s;
	species_t            inc_s;
	logic                commit;
	logic [ADDR_W-1:0]   commit_addr;
	species_t            commit_data;
	logic [ATT_W-1:0]    att_nx;
	count_t              cnt_nx [3];
	species_t            ext_post;
	logic                lim_post;
	result_t             res_nx;

	always_comb begin
		ext_pre  = first_extinct(cnt_q[0], cnt_q[1], cnt_q[2]);
		lim_pre  = (limit_q != '0) && (att_q >= limit_q);
		ref_wins = (prey_of(rd_ref_s1) == rd_nbr_s1);
		winner   = ref_wins ? rd_ref_s1 : rd_nbr_s1;
		loser    = ref_wins ? rd_nbr_s1 : rd_ref_s1;

		case (winner)
			SP_ROCK:     rate_sel = rate_q[0];
			SP_PAPER:    rate_sel = rate_q[1];
			SP_SCISSORS: rate_sel = rate_q[2];
			default:     rate_sel = '0;
		endcase

		// zero never hits, 2^RATE_BITS and above always hits
		if (rate_sel == '0)
			hit = 1'b0;
		else if (rate_sel[RATE_BITS])
			hit = 1'b1;
		else
			hit = item_s1.random_fraction < rate_sel[RATE_BITS-1:0];

		interact = ref_ok_s1 && nbr_ok_s1 && (rd_ref_s1 != rd_nbr_s1) &&
			(rd_ref_s1 != SP_NONE) && (rd_nbr_s1 != SP_NONE) && hit;

		active      = 1'b0;
		dec_en      = 1'b0;
		inc_en      = 1'b0;
		dec_s       = loser;
		inc_s       = winner;
		commit      = 1'b0;
		commit_addr = ref_wins ? item_s1.neighbour_node[ADDR_W-1:0]
			: item_s1.reference_node[ADDR_W-1:0];
		commit_data = winner;
		att_nx      = att_q;

		if (item_s1.operation == OP_LOAD) begin
			att_nx = '0;
			if (item_s1.load_species != SP_NONE && ref_ok_s1) begin
				dec_en      = 1'b1;
				inc_en      = 1'b1;
				dec_s       = rd_ref_s1;
				inc_s       = item_s1.load_species;
				commit      = 1'b1;
				commit_addr = item_s1.reference_node[ADDR_W-1:0];
				commit_data = item_s1.load_species;
			end
		end else if (ext_pre == SP_NONE && !lim_pre) begin
			active = 1'b1;
			att_nx = (att_q == ATT_MAX) ? att_q : att_q + 1'b1;
			if (interact) begin
				dec_en = 1'b1;
				inc_en = 1'b1;
				commit = 1'b1;
			end
		end

		// decrement first, then increment, both saturating
		for (int k = 0; k < 3; k++) begin
			cnt_nx[k] = cnt_q[k];
			if (dec_en && dec_s == species_t'(k) && cnt_nx[k] != '0)
				cnt_nx[k] = cnt_nx[k] - 1'b1;
			if (inc_en && inc_s == species_t'(k) && cnt_nx[k] < CNT_SAT)
				cnt_nx[k] = cnt_nx[k] + 1'b1;
		end

		ext_post = first_extinct(cnt_nx[0], cnt_nx[1], cnt_nx[2]);
		lim_post = (limit_q != '0) && (att_nx >= limit_q);

		res_nx.replaced = active && interact;
		if (item_s1.operation == OP_LOAD || active) begin
			if (ext_post != SP_NONE)
				res_nx.outcome = OUT_EXTINCT;
			else if (active && lim_post)
				res_nx.outcome = OUT_LIMIT;
			else
				res_nx.outcome = OUT_RUNNING;
		end else if (ext_pre != SP_NONE) begin
			res_nx.outcome = OUT_EXTINCT;
		end else begin
			res_nx.outcome = OUT_LIMIT;
		end
		res_nx.extinct_kind   = ext_post;
		res_nx.attempts_done  = att_nx;
		res_nx.rock_total     = cnt_nx[0][TOTAL_W-1:0];
		res_nx.paper_total    = cnt_nx[1][TOTAL_W-1:0];
		res_nx.scissors_total = cnt_nx[2][TOTAL_W-1:0];
	end

	// Memory write port: clearing pass or write-back
	assign wr_en   = clr_busy_q || (exec_fire && commit);
	assign wr_addr = clr_busy_q ? clr_addr_q : commit_addr;
	assign wr_data = clr_busy_q ? SP_ROCK : commit_data;

	// Control, counters, configuration and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			cnt_q[0]    <= NODES_C;
			cnt_q[1]    <= '0;
			cnt_q[2]    <= '0;
			att_q       <= '0;
			rate_q[0]   <= RATE_W'(1 << RATE_BITS);
			rate_q[1]   <= RATE_W'(1 << RATE_BITS);
			rate_q[2]   <= RATE_W'(1 << RATE_BITS);
			limit_q     <= '0;
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
		end else begin
			// clearing pass after reset
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == LAST_ADDR)
					clr_busy_q <= 1'b0;
			end

			if (cfg.valid) begin
				case (cfg_req.reg_index)
					REG_RATE_ROCK:     rate_q[0] <= cfg_req.data[RATE_W-1:0];
					REG_RATE_PAPER:    rate_q[1] <= cfg_req.data[RATE_W-1:0];
					REG_RATE_SCISSORS: rate_q[2] <= cfg_req.data[RATE_W-1:0];
					REG_ATTEMPT_LIMIT: limit_q   <= cfg_req.data;
					default: ;
				endcase
			end

			// a new result replaces the one taken in the same cycle
			if (exec_fire)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (item_fire)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (exec_fire) begin
						state_q     <= ST_IDLE;
						res_q       <= res_nx;
						cnt_q       <= cnt_nx;
						att_q       <= att_nx;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- tb/sv/cdis_invasion_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cyclic dominance invasion step: channel monitor and result check
// Watches the request, configuration and result channels, keeps its own copy
// of the lattice, species counts, attempt counter and registers, and compares
// each result against the outcome predicted for the oldest pending request.
// ----------------------------------------------------------------------------
module cdis_invasion_monitor
	import cdis_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	cdis_chan_if item,
	cdis_chan_if cfg,
	cdis_chan_if result,
	output int   fail_count,
	output int   outstanding
);

	localparam int NODE_COUNT = 4096;
	localparam logic [RATE_W-1:0] RATE_ALWAYS = RATE_W'(1) << RATE_BITS;

	// Species each code defeats: rock > scissors, paper > rock, scissors > paper
	localparam species_t PREY [3] = '{SP_SCISSORS, SP_ROCK, SP_PAPER};

	// Mirror of the block state
	species_t          lattice [NODE_COUNT];
	count_t            pop [3];
	logic [ATT_W-1:0]  tries;
	logic [ATT_W-1:0]  try_limit;
	logic [RATE_W-1:0] win_rate [3];

	result_t expected_results [$];

	function automatic logic node_exists(input logic [NODE_W-1:0] n);
		return 32'(n) < NODE_COUNT;
	endfunction

	function automatic void count_drop(input species_t s);
		if (s != SP_NONE && pop[s] != '0)
			pop[s]--;
	endfunction

	function automatic void count_add(input species_t s);
		if (s != SP_NONE && pop[s] != CNT_SAT)
			pop[s]++;
	endfunction

	// Rock is checked first, then paper, then scissors
	function automatic species_t lowest_extinct();
		for (int s = 0; s < 3; s++)
			if (pop[s] == '0)
				return species_t'(s);
		return SP_NONE;
	endfunction

	function automatic logic limit_hit();
		return try_limit != '0 && tries >= try_limit;
	endfunction

	// Apply one request to the mirror state and return the result it yields
	function automatic result_t predict_invasion(input item_t req);
		result_t  exp_r;
		species_t src_sp;
		species_t nbr_sp;
		species_t winner;
		species_t loser;
		logic [NODE_W-1:0] loser_node;
		logic     src_wins;
		exp_r = '0;
		if (req.operation == OP_LOAD) begin
			tries = '0;
			if (req.load_species != SP_NONE && node_exists(req.reference_node)) begin
				count_drop(lattice[req.reference_node]);
				lattice[req.reference_node] = req.load_species;
				count_add(req.load_species);
			end
			exp_r.outcome = (lowest_extinct() != SP_NONE) ? OUT_EXTINCT : OUT_RUNNING;
		end else if (lowest_extinct() != SP_NONE) begin
			// nothing left to compete: no count, no change
			exp_r.outcome = OUT_EXTINCT;
		end else if (limit_hit()) begin
			exp_r.outcome = OUT_LIMIT;
		end else begin
			if (tries != ATT_MAX)
				tries++;
			if (node_exists(req.reference_node) && node_exists(req.neighbour_node)) begin
				src_sp = lattice[req.reference_node];
				nbr_sp = lattice[req.neighbour_node];
				if (src_sp != nbr_sp) begin
					src_wins   = (PREY[src_sp] == nbr_sp);
					winner     = src_wins ? src_sp : nbr_sp;
					loser      = src_wins ? nbr_sp : src_sp;
					loser_node = src_wins ? req.neighbour_node : req.reference_node;
					// rate 0 never hits, a full rate always does
					if ({1'b0, req.random_fraction} < win_rate[winner]) begin
						count_drop(loser);
						count_add(winner);
						lattice[loser_node] = winner;
						exp_r.replaced = 1'b1;
					end
				end
			end
			// extinction wins over the limit on the same attempt
			if (lowest_extinct() != SP_NONE)
				exp_r.outcome = OUT_EXTINCT;
			else if (limit_hit())
				exp_r.outcome = OUT_LIMIT;
			else
				exp_r.outcome = OUT_RUNNING;
		end
		exp_r.extinct_kind   = lowest_extinct();
		exp_r.attempts_done  = tries;
		exp_r.rock_total     = pop[SP_ROCK][TOTAL_W-1:0];
		exp_r.paper_total    = pop[SP_PAPER][TOTAL_W-1:0];
		exp_r.scissors_total = pop[SP_SCISSORS][TOTAL_W-1:0];
		return exp_r;
	endfunction

	function automatic void apply_register(input cfg_t w);
		case (w.reg_index)
			REG_RATE_ROCK:     win_rate[SP_ROCK]     = w.data[RATE_W-1:0];
			REG_RATE_PAPER:    win_rate[SP_PAPER]    = w.data[RATE_W-1:0];
			REG_RATE_SCISSORS: win_rate[SP_SCISSORS] = w.data[RATE_W-1:0];
			REG_ATTEMPT_LIMIT: try_limit             = w.data;
			default: ;
		endcase
	endfunction

	function automatic void check_field(input string field, input logic [ATT_W-1:0] want,
		input logic [ATT_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endfunction

	function automatic void compare_result(input result_t want, input result_t got);
		check_field("replaced", ATT_W'(want.replaced), ATT_W'(got.replaced));
		check_field("outcome", ATT_W'(want.outcome), ATT_W'(got.outcome));
		check_field("extinct_kind", ATT_W'(want.extinct_kind), ATT_W'(got.extinct_kind));
		check_field("attempts_done", want.attempts_done, got.attempts_done);
		check_field("rock_total", ATT_W'(want.rock_total), ATT_W'(got.rock_total));
		check_field("paper_total", ATT_W'(want.paper_total), ATT_W'(got.paper_total));
		check_field("scissors_total", ATT_W'(want.scissors_total),
			ATT_W'(got.scissors_total));
	endfunction

	// Handshakes are sampled at the rising edge, before any update lands
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (lattice[n])
				lattice[n] = SP_ROCK;
			pop[SP_ROCK]     = count_t'(NODE_COUNT);
			pop[SP_PAPER]    = '0;
			pop[SP_SCISSORS] = '0;
			tries     = '0;
			try_limit = '0;
			foreach (win_rate[s])
				win_rate[s] = RATE_ALWAYS;
			expected_results.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no request pending");
					fail_count++;
				end else begin
					compare_result(expected_results.pop_front(), result.payload);
				end
			end
			if (cfg.valid && cfg.ready)
				apply_register(cfg.payload);
			if (item.valid && item.ready)
				expected_results.push_back(predict_invasion(item.payload));
			outstanding <= expected_results.size();
		end
	end

endmodule

// ----- tb/sv/tb_cyclic_dominance_invasion_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cyclic dominance invasion step: testbench top
// Drives load and attempt requests plus register writes: a directed opening,
// then episodes of local loads followed by invasion attempts under several
// rate and limit settings, ending with a stretch without idling. Result
// checking is done by the channel monitor; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_cyclic_dominance_invasion_step;
	import cdis_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_REQS  = 370;
	localparam int FINAL_REQS  = 200;
	localparam int LATTICE     = 4096;
	localparam logic [RATE_W-1:0] RATE_ALWAYS = RATE_W'(1) << RATE_BITS;

	logic clk = 1'b0;
	logic arst_n;

	int          fail_count;
	int          outstanding;
	int unsigned requests_sent = 0;
	int unsigned cycle_count;
	int          src_idle_pct  = 0;
	int          sink_idle_pct = 0;
	logic        hold_results  = 1'b0;

	cdis_chan_if #(.payload_t(item_t))   item_ch ();
	cdis_chan_if #(.payload_t(cfg_t))    cfg_ch ();
	cdis_chan_if #(.payload_t(result_t)) result_ch ();

	cyclic_dominance_invasion_step dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.cfg    (cfg_ch),
		.result (result_ch)
	);

	cdis_invasion_monitor invasion_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.cfg         (cfg_ch),
		.result      (result_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// Result side: random stall bursts, and one long hold when asked
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_results) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_results = 1'b0;
				result_ch.ready <= 1'b1;
			end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	function automatic item_t make_request(input logic op, input logic [NODE_W-1:0] src_node,
		input logic [NODE_W-1:0] nbr_node, input logic [RND_W-1:0] rnd, input species_t sp);
		item_t r;
		r.operation       = op;
		r.reference_node  = src_node;
		r.neighbour_node  = nbr_node;
		r.random_fraction = rnd;
		r.load_species    = sp;
		return r;
	endfunction

	function automatic logic [RATE_W-1:0] pick_rate();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return RATE_W'(1);
			2:       return RATE_W'(65535);
			3:       return RATE_ALWAYS;
			default: return RATE_W'($urandom_range(0, 65536));
		endcase
	endfunction

	// Offer one request, hold it until taken, then maybe go idle for a burst
	task automatic send(input item_t req);
		item_ch.valid   <= 1'b1;
		item_ch.payload <= req;
		do @(posedge clk); while (!item_ch.ready);
		requests_sent++;
		if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic load_node(input logic [NODE_W-1:0] node, input species_t sp);
		send(make_request(OP_LOAD, node, NODE_W'($urandom), RND_W'($urandom), sp));
	endtask

	task automatic try_invasion(input logic [NODE_W-1:0] src_node,
		input logic [NODE_W-1:0] nbr_node, input logic [RND_W-1:0] rnd);
		send(make_request(OP_ATTEMPT, src_node, nbr_node, rnd, species_t'($urandom)));
	endtask

	// Stop offering and wait until every result is back, plus a margin
	task automatic drain_results();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Leaves valid high; the caller lowers it after the last write
	task automatic write_register(input reg_idx_t idx, input logic [ATT_W-1:0] val);
		cfg_ch.valid   <= 1'b1;
		cfg_ch.payload <= '{reg_index: idx, data: val};
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic configure(input logic [RATE_W-1:0] rock_rate,
		input logic [RATE_W-1:0] paper_rate, input logic [RATE_W-1:0] scissors_rate,
		input logic [ATT_W-1:0] limit_val);
		drain_results();
		write_register(REG_RATE_ROCK, ATT_W'(rock_rate));
		write_register(REG_RATE_PAPER, ATT_W'(paper_rate));
		write_register(REG_RATE_SCISSORS, ATT_W'(scissors_rate));
		write_register(REG_ATTEMPT_LIMIT, limit_val);
		cfg_ch.valid <= 1'b0;
	endtask

	// Load a small window of nodes, then let them compete; some noise mixed in
	task automatic run_episode();
		logic [NODE_W-1:0] base;
		int span;
		int n_tries;
		span    = $urandom_range(2, 16);
		base    = NODE_W'($urandom_range(0, LATTICE - 1 - span));
		n_tries = $urandom_range(4, 40);
		for (int k = 0; k < span; k++)
			load_node(base + NODE_W'(k), species_t'($urandom_range(0, 2)));
		for (int k = 0; k < n_tries; k++) begin
			if ($urandom_range(0, 9) == 0)
				send(make_request(1'($urandom), NODE_W'($urandom), NODE_W'($urandom),
					RND_W'($urandom), species_t'($urandom)));
			else
				try_invasion(base + NODE_W'($urandom_range(0, span - 1)),
					base + NODE_W'($urandom_range(0, span - 1)), RND_W'($urandom));
		end
	endtask

	task automatic run_phase(input int n_reqs);
		int unsigned target;
		target = requests_sent + n_reqs;
		while (requests_sent < target)
			run_episode();
	endtask

	initial begin
		item_ch.valid   <= 1'b0;
		item_ch.payload <= '0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.payload  <= '0;
		arst_n          <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset populations, loads, same-node and same-species attempts
		src_idle_pct  = 15;
		sink_idle_pct = 5;
		try_invasion(12'd0, 12'd1, 16'd0);              // paper and scissors extinct
		load_node(12'd0, SP_PAPER);
		load_node(12'd1, SP_SCISSORS);
		load_node(12'd5, SP_PAPER);
		load_node(12'd2, SP_NONE);                      // code 3 writes nothing
		load_node(12'd4095, SP_SCISSORS);
		try_invasion(12'd0, 12'd1, 16'hFFFF);           // neighbour wins
		try_invasion(12'd5, 12'd5, 16'd0);              // same node
		try_invasion(12'd2, 12'd3, 16'd0);              // rock against rock
		try_invasion(12'd4095, 12'd5, 16'h8000);        // takes the last paper

		// Rate edges and the attempt limit
		configure('0, RATE_W'(1), RATE_W'(65535), ATT_W'(3));
		load_node(12'd0, SP_PAPER);
		try_invasion(12'd2, 12'd0, 16'd0);              // paper hits at rate 1
		try_invasion(12'd0, 12'd3, 16'd1);              // paper misses at rate 1
		try_invasion(12'd3, 12'd4095, 16'd0);           // rock never hits, limit reached
		try_invasion(12'd4095, 12'd0, 16'd0);           // past the limit
		load_node(12'd5, SP_PAPER);
		try_invasion(12'd4095, 12'd0, 16'hFFFF);        // just misses
		try_invasion(12'd0, 12'd4095, 16'hFFFE);        // just hits

		// Extinction and limit on the same attempt
		configure(RATE_ALWAYS, RATE_ALWAYS, RATE_ALWAYS, ATT_W'(1));
		load_node(12'd2, SP_ROCK);
		load_node(12'd5, SP_ROCK);
		load_node(12'd7, SP_PAPER);
		try_invasion(12'd4095, 12'd7, 16'd0);

		// Random episodes under varied settings
		configure(pick_rate(), pick_rate(), pick_rate(), '0);
		src_idle_pct  = 30;
		sink_idle_pct = 10;
		run_phase(PHASE_REQS);

		configure(pick_rate(), pick_rate(), pick_rate(), ATT_W'($urandom_range(5, 40)));
		src_idle_pct  = 60;
		sink_idle_pct = 3;
		run_phase(PHASE_REQS);

		// No idling; results held back for a long stretch while requests keep coming
		configure('0, RATE_ALWAYS, RATE_W'(32768), ATT_MAX);
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		hold_results  = 1'b1;
		run_phase(PHASE_REQS);

		configure(pick_rate(), pick_rate(), pick_rate(), ATT_W'($urandom_range(1, 20)));
		src_idle_pct  = 10;
		sink_idle_pct = 25;
		run_phase(PHASE_REQS);

		// Closing stretch at full rate on both sides
		configure(pick_rate(), pick_rate(), pick_rate(), '0);
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		run_phase(FINAL_REQS);

		drain_results();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/cdis_pkg.sv
rtl/cdis_chan_if.sv
rtl/cyclic_dominance_invasion_step.sv
tb/sv/cdis_invasion_monitor.sv
tb/sv/tb_cyclic_dominance_invasion_step.sv
